// ----- hdl/cbf_pkg.sv -----
// Shared types, constants and helper functions for the ChaCha block function.
// Used by cbf_front, cbf_core, cbf_checker and the top level; depends on nothing else.
package cbf_pkg;

  localparam int STATE_WORDS = 16;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int ROUND_W     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LANES       = 4;

  localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(STATE_WORDS - 1);
  localparam logic [ROUND_W-1:0] ROUNDS_RESET  = ROUND_W'(10);
  localparam logic [ROUND_W-1:0] ROUND_ONE     = ROUND_W'(1);

  // Positions of the four words inside one quarter round.
  localparam logic [1:0] POS_A = 2'd0;
  localparam logic [1:0] POS_B = 2'd1;
  localparam logic [1:0] POS_C = 2'd2;
  localparam logic [1:0] POS_D = 2'd3;

  // Last of the four add/xor/rotate steps of a quarter round.
  localparam logic [1:0] STEP_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } cbf_state_e;

  // One queued input word, tagged with whether it closes a block.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } cbf_word_t;

  // State index of a quarter-round operand. Row is the operand position,
  // the column shifts by the position for diagonal rounds.
  function automatic logic [IDX_W-1:0] qr_index(input logic       diag,
                                                input logic [1:0] lane,
                                                input logic [1:0] pos);
    logic [1:0] col;
    col = diag ? (lane + pos) : lane;
    return {pos, col};
  endfunction

  // Rotate left by 16, 12, 8 or 7 for steps zero to three.
  function automatic logic [WORD_W-1:0] rot_step(input logic [WORD_W-1:0] v,
                                                 input logic [1:0]        step);
    logic [WORD_W-1:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/cbf_front.sv -----
// Input side of the ChaCha block function: accepts words, tags the sixteenth
// word of each block and holds them in a small queue. Depends on cbf_pkg.
module cbf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [cbf_pkg::WORD_W-1:0]   s_tdata_i,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output cbf_pkg::cbf_word_t           q_item_o
);

  cbf_pkg::cbf_word_t                  mem_q [cbf_pkg::QUEUE_DEPTH];
  logic [cbf_pkg::QPTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [cbf_pkg::QPTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [cbf_pkg::QPTR_W:0]            count_q, count_d;
  logic [cbf_pkg::IDX_W-1:0]           word_cnt_q, word_cnt_d;
  logic                                push, pop;
  cbf_pkg::cbf_word_t                  entry;

  assign s_tready_o = (count_q != (cbf_pkg::QPTR_W+1)'(cbf_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  assign push = s_tvalid_i && s_tready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    entry.word = s_tdata_i;
    entry.last = (word_cnt_q == cbf_pkg::LAST_IDX);
    wr_ptr_d   = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d   = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    word_cnt_d = push ? word_cnt_q + 1'b1 : word_cnt_q;
    count_d    = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      word_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
      word_cnt_q <= word_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ----- hdl/cbf_core.sv -----
// Round engine of the ChaCha block function: loads a block from the queue,
// runs the double rounds on four quarter-round lanes and emits the key words.
// Depends on cbf_pkg.
module cbf_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbf_pkg::ROUND_W-1:0]   cfg_wdata_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  cbf_pkg::cbf_word_t            q_item_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [cbf_pkg::WORD_W-1:0]    m_tdata_o,
  output logic                          m_tlast_o
);

  cbf_pkg::cbf_state_e               state_q, state_d;
  logic [cbf_pkg::WORD_W-1:0]        orig_q [cbf_pkg::STATE_WORDS];
  logic [cbf_pkg::WORD_W-1:0]        orig_d [cbf_pkg::STATE_WORDS];
  logic [cbf_pkg::WORD_W-1:0]        work_q [cbf_pkg::STATE_WORDS];
  logic [cbf_pkg::WORD_W-1:0]        work_d [cbf_pkg::STATE_WORDS];
  logic [cbf_pkg::ROUND_W-1:0]       cfg_q, cfg_d;
  logic [cbf_pkg::ROUND_W-1:0]       rounds_q, rounds_d;
  logic                              half_q, half_d;
  logic [1:0]                        step_q, step_d;
  logic [cbf_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic                              out_valid_q, out_valid_d;
  logic [cbf_pkg::WORD_W-1:0]        out_data_q, out_data_d;
  logic                              out_last_q, out_last_d;
  logic                              out_free;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign out_free   = !out_valid_q || m_tready_i;
  assign cfg_d      = cfg_we_i ? cfg_wdata_i : cfg_q;

  always_comb begin
    logic [cbf_pkg::IDX_W-1:0]  ix, iy, iz;
    logic [cbf_pkg::WORD_W-1:0] sum;
    state_d     = state_q;
    orig_d      = orig_q;
    work_d      = work_q;
    rounds_d    = rounds_q;
    half_d      = half_q;
    step_d      = step_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    q_ready_o   = 1'b0;
    ix          = '0;
    iy          = '0;
    iz          = '0;
    sum         = '0;
    case (state_q)
      cbf_pkg::ST_LOAD: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          // Words arrive in order, so shifting down leaves word 0 at index 0.
          for (int i = 0; i < cbf_pkg::STATE_WORDS - 1; i++) begin
            orig_d[i] = orig_q[i+1];
            work_d[i] = work_q[i+1];
          end
          orig_d[cbf_pkg::STATE_WORDS-1] = q_item_i.word;
          work_d[cbf_pkg::STATE_WORDS-1] = q_item_i.word;
          if (q_item_i.last) begin
            rounds_d = cfg_q;
            half_d   = 1'b0;
            step_d   = '0;
            idx_d    = '0;
            state_d  = (cfg_q == '0) ? cbf_pkg::ST_OUT : cbf_pkg::ST_ROUND;
          end
        end
      end
      cbf_pkg::ST_ROUND: begin
        // Each lane does one add, xor and rotate of its quarter round.
        for (int l = 0; l < cbf_pkg::LANES; l++) begin
          ix  = cbf_pkg::qr_index(half_q, 2'(l),
                                  step_q[0] ? cbf_pkg::POS_C : cbf_pkg::POS_A);
          iy  = cbf_pkg::qr_index(half_q, 2'(l),
                                  step_q[0] ? cbf_pkg::POS_D : cbf_pkg::POS_B);
          iz  = cbf_pkg::qr_index(half_q, 2'(l),
                                  step_q[0] ? cbf_pkg::POS_B : cbf_pkg::POS_D);
          sum = work_q[ix] + work_q[iy];
          work_d[ix] = sum;
          work_d[iz] = cbf_pkg::rot_step(work_q[iz] ^ sum, step_q);
        end
        step_d = step_q + 1'b1;
        if (step_q == cbf_pkg::STEP_LAST) begin
          half_d = !half_q;
          if (half_q) begin
            rounds_d = rounds_q - 1'b1;
            if (rounds_q == cbf_pkg::ROUND_ONE) begin
              state_d = cbf_pkg::ST_OUT;
            end
          end
        end
      end
      cbf_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = work_q[0] + orig_q[0];
          out_last_d  = (idx_q == cbf_pkg::LAST_IDX);
          for (int i = 0; i < cbf_pkg::STATE_WORDS - 1; i++) begin
            orig_d[i] = orig_q[i+1];
            work_d[i] = work_q[i+1];
          end
          idx_d = idx_q + 1'b1;
          if (idx_q == cbf_pkg::LAST_IDX) begin
            state_d = cbf_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = cbf_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbf_pkg::ST_LOAD;
      cfg_q       <= cbf_pkg::ROUNDS_RESET;
      rounds_q    <= '0;
      half_q      <= 1'b0;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      rounds_q    <= rounds_d;
      half_q      <= half_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    orig_q     <= orig_d;
    work_q     <= work_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

endmodule

// ----- hdl/chacha_block_function.sv -----
// Top level of the ChaCha block function: input queue front end and round
// engine back end. Depends on cbf_pkg, cbf_front and cbf_core.
//
//  Channel  | Direction | Signals                         | Contents
//  ---------+-----------+---------------------------------+-------------------------------
//  s        | in        | s_tvalid_i s_tready_o s_tdata_i | one input state word per transfer
//  m        | out       | m_tvalid_o m_tready_i m_tdata_o | one key word per transfer,
//           |           | m_tlast_o                       | tlast on the sixteenth word
//  cfg      | in        | cfg_we_i cfg_wdata_i            | double round count, write only
//
// The round engine pulls the sixteen words of a block out of the queue, runs
// the configured double rounds (four lanes each take one add, xor and rotate
// step per cycle, four steps per quarter round), emits the sixteen key words,
// and only then loads the next block. Reset clears the word counter, the queue
// and the engine state and sets the round count to ten. The four-entry input
// queue keeps taking words while the engine is busy, and the output register
// holds a word while tready is low.
module chacha_block_function (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbf_pkg::ROUND_W-1:0]  cfg_wdata_i,   // double_round_count
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [cbf_pkg::WORD_W-1:0]   s_tdata_i,     // [31:0] state_word
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [cbf_pkg::WORD_W-1:0]   m_tdata_o,     // [31:0] key_word
  output logic                         m_tlast_o      // last_word
);

  logic               q_valid;
  logic               q_ready;
  cbf_pkg::cbf_word_t q_item;

  // Front end: takes each transfer, marks the word that closes a block.
  cbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // Back end: loads the block, runs the rounds, streams out the key words.
  cbf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

endmodule

// ----- hdl/cbf_checker.sv -----
// Port-level checks for the ChaCha block function, bound to the top level.
// Depends on cbf_pkg and on the port names of chacha_block_function.
module cbf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_tvalid_i,
  input logic                        s_tready_o,
  input logic                        m_tvalid_o,
  input logic                        m_tready_i,
  input logic [cbf_pkg::WORD_W-1:0]  m_tdata_o,
  input logic                        m_tlast_o
);

  logic [cbf_pkg::IDX_W-1:0] in_cnt_q;
  logic [cbf_pkg::IDX_W-1:0] out_cnt_q;
  logic [1:0]                pending_q;
  logic                      in_fire, out_fire, in_block, out_block;

  assign in_fire   = s_tvalid_i && s_tready_o;
  assign out_fire  = m_tvalid_o && m_tready_i;
  assign in_block  = in_fire && (in_cnt_q == cbf_pkg::LAST_IDX);
  assign out_block = out_fire && m_tlast_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pending_q <= '0;
    end else begin
      if (in_fire) begin
        in_cnt_q <= in_cnt_q + 1'b1;
      end
      if (out_fire) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end
      if (in_block && !out_block) begin
        pending_q <= pending_q + 1'b1;
      end else if (out_block && !in_block) begin
        pending_q <= pending_q - 1'b1;
      end
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("output payload changed while stalled");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (m_tlast_o == (out_cnt_q == cbf_pkg::LAST_IDX)))
    else $error("tlast not on the sixteenth word of a block");

  a_no_early_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (pending_q != '0))
    else $error("output word without a complete input block");

endmodule

bind chacha_block_function cbf_checker u_cbf_checker (.*);
